// ----- hdl/lpr_pkg.sv -----
// Shared constants and helpers for the line pixel rasterizer.
package lpr_pkg;

	localparam int COLOR_BITS = 24;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_NEXT = 1'b1;

	// Width of one decoded queue entry for a given coordinate width.
	function automatic int entry_bits(input int coord_bits);
		return 5 * coord_bits + 29;
	endfunction

endpackage

// ----- hdl/lpr_line_if.sv -----
// Command channel carrying load and next requests with the line endpoints.
interface lpr_line_if import lpr_pkg::*; #(
	parameter int COORD_BITS = 13
);
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic signed [COORD_BITS-1:0]  start_x;
	logic signed [COORD_BITS-1:0]  start_y;
	logic signed [COORD_BITS-1:0]  end_x;
	logic signed [COORD_BITS-1:0]  end_y;
	logic        [COLOR_BITS-1:0]  pixel_color;

	modport source (
		output valid, command, start_x, start_y, end_x, end_y, pixel_color,
		input  ready
	);
	modport sink (
		input  valid, command, start_x, start_y, end_x, end_y, pixel_color,
		output ready
	);
endinterface

// ----- hdl/lpr_pixel_if.sv -----
// Result channel carrying one rasterized pixel per transfer.
interface lpr_pixel_if import lpr_pkg::*; #(
	parameter int COORD_BITS = 13
);
	logic                          valid;
	logic                          ready;
	logic                          pixel_valid;
	logic signed [COORD_BITS-1:0]  pixel_x;
	logic signed [COORD_BITS-1:0]  pixel_y;
	logic        [COLOR_BITS-1:0]  color_out;
	logic                          last_pixel;

	modport source (
		output valid, pixel_valid, pixel_x, pixel_y, color_out, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_valid, pixel_x, pixel_y, color_out, last_pixel,
		output ready
	);
endinterface

// ----- hdl/lpr_fifo.sv -----
// Small register queue between the classifying front and the drawing back end.
module lpr_fifo import lpr_pkg::*; #(
	parameter int WIDTH = 94,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full      = (count_q == CNT_BITS'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ----- hdl/lpr_front.sv -----
// Front end: takes commands, picks the major axis and orders the endpoints.
module lpr_front import lpr_pkg::*; #(
	parameter int COORD_BITS = 13
) (
	input  logic                                clk,
	input  logic                                arst_n,
	lpr_line_if.sink                            line_in,
	output logic                                push,
	output logic [entry_bits(COORD_BITS)-1:0]   push_entry,
	input  logic                                full
);
	localparam int W = COORD_BITS;
	localparam int D = COORD_BITS + 1;

	typedef struct packed {
		logic                  load;
		logic                  major_is_x;
		logic signed [W-1:0]   major_start;
		logic signed [W-1:0]   major_end;
		logic signed [W-1:0]   minor_start;
		logic                  minor_fall;
		logic [D-1:0]          major_span;
		logic [D-1:0]          minor_span;
		logic [COLOR_BITS-1:0] color;
	} entry_t;

	logic                  valid_s1;
	logic                  command_s1;
	logic signed [W-1:0]   x0_s1, y0_s1, x1_s1, y1_s1;
	logic [COLOR_BITS-1:0] color_s1;

	logic signed [D-1:0]   dx, dy, dmn;
	logic [D-1:0]          adx, ady, amj, amn;
	logic                  major_is_x, swap;
	entry_t                entry;

	assign line_in.ready = !valid_s1 || !full;
	assign push          = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_in.ready) begin
			valid_s1 <= line_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line_in.valid && line_in.ready) begin
			command_s1 <= line_in.command;
			x0_s1      <= line_in.start_x;
			y0_s1      <= line_in.start_y;
			x1_s1      <= line_in.end_x;
			y1_s1      <= line_in.end_y;
			color_s1   <= line_in.pixel_color;
		end
	end

	always_comb begin
		dx         = D'(x1_s1) - D'(x0_s1);
		dy         = D'(y1_s1) - D'(y0_s1);
		adx        = dx[D-1] ? D'(-dx) : D'(dx);
		ady        = dy[D-1] ? D'(-dy) : D'(dy);
		major_is_x = (adx >= ady);
		swap       = major_is_x ? dx[D-1] : dy[D-1];
		dmn        = major_is_x ? dy : dx;
		amj        = major_is_x ? adx : ady;
		amn        = major_is_x ? ady : adx;

		entry.load       = (command_s1 == CMD_LOAD);
		entry.major_is_x = major_is_x;
		if (major_is_x) begin
			entry.major_start = swap ? x1_s1 : x0_s1;
			entry.major_end   = swap ? x0_s1 : x1_s1;
			entry.minor_start = swap ? y1_s1 : y0_s1;
		end else begin
			entry.major_start = swap ? y1_s1 : y0_s1;
			entry.major_end   = swap ? y0_s1 : y1_s1;
			entry.minor_start = swap ? x1_s1 : x0_s1;
		end
		entry.minor_fall = swap ? (!dmn[D-1] && (dmn != '0)) : dmn[D-1];
		entry.major_span = amj + 1'b1;
		entry.minor_span = (amn == '0) ? '0 : amn + 1'b1;
		entry.color      = color_s1;
	end

	assign push_entry = entry;
endmodule

// ----- hdl/lpr_back.sv -----
// Back end: holds the active line and steps it one pixel per queue entry.
module lpr_back import lpr_pkg::*; #(
	parameter int COORD_BITS = 13
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                entry_valid,
	input  logic [entry_bits(COORD_BITS)-1:0]   entry_in,
	output logic                                pop,
	lpr_pixel_if.source                         pixel_out
);
	localparam int W = COORD_BITS;
	localparam int D = COORD_BITS + 1;

	typedef struct packed {
		logic                  load;
		logic                  major_is_x;
		logic signed [W-1:0]   major_start;
		logic signed [W-1:0]   major_end;
		logic signed [W-1:0]   minor_start;
		logic                  minor_fall;
		logic [D-1:0]          major_span;
		logic [D-1:0]          minor_span;
		logic [COLOR_BITS-1:0] color;
	} entry_t;

	entry_t                e;

	logic                  active_q;
	logic                  major_is_x_q;
	logic signed [W-1:0]   major_cur_q, major_end_q, minor_cur_q;
	logic                  minor_fall_q;
	logic [D-1:0]          major_span_q, minor_span_q, acc_q;
	logic [COLOR_BITS-1:0] color_q;

	logic                  out_valid_q;
	logic                  pix_valid_q;
	logic signed [W-1:0]   pix_x_q, pix_y_q;
	logic [COLOR_BITS-1:0] pix_color_q;
	logic                  pix_last_q;

	logic                  out_free;
	logic                  emit;
	logic                  c_major_is_x, c_minor_fall, last;
	logic signed [W-1:0]   c_major, c_end, c_minor;
	logic [D-1:0]          c_major_span, c_minor_span, c_acc;
	logic [COLOR_BITS-1:0] c_color;
	logic [D:0]            acc_sum;
	logic                  step_minor;
	logic [D-1:0]          acc_next;
	logic signed [W-1:0]   minor_next;

	assign e        = entry_in;
	assign out_free = !out_valid_q || pixel_out.ready;
	assign pop      = entry_valid && out_free;

	always_comb begin
		c_major_is_x = e.load ? e.major_is_x  : major_is_x_q;
		c_major      = e.load ? e.major_start : major_cur_q;
		c_end        = e.load ? e.major_end   : major_end_q;
		c_minor      = e.load ? e.minor_start : minor_cur_q;
		c_minor_fall = e.load ? e.minor_fall  : minor_fall_q;
		c_major_span = e.load ? e.major_span  : major_span_q;
		c_minor_span = e.load ? e.minor_span  : minor_span_q;
		c_acc        = e.load ? '0            : acc_q;
		c_color      = e.load ? e.color       : color_q;
		emit         = e.load || active_q;
		last         = (c_major == c_end);
		acc_sum      = {1'b0, c_acc} + {1'b0, c_minor_span};
		step_minor   = (acc_sum >= {1'b0, c_major_span});
		acc_next     = step_minor ? D'(acc_sum - {1'b0, c_major_span}) : D'(acc_sum);
		minor_next   = step_minor ? (c_minor_fall ? c_minor - 1'b1 : c_minor + 1'b1)
		                          : c_minor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			major_is_x_q <= 1'b0;
			major_cur_q  <= '0;
			major_end_q  <= '0;
			minor_cur_q  <= '0;
			minor_fall_q <= 1'b0;
			major_span_q <= '0;
			minor_span_q <= '0;
			acc_q        <= '0;
			color_q      <= '0;
		end else if (pop && emit) begin
			active_q     <= !last;
			major_is_x_q <= c_major_is_x;
			major_end_q  <= c_end;
			minor_fall_q <= c_minor_fall;
			major_span_q <= c_major_span;
			minor_span_q <= c_minor_span;
			color_q      <= c_color;
			major_cur_q  <= last ? c_major : c_major + 1'b1;
			minor_cur_q  <= last ? c_minor : minor_next;
			acc_q        <= last ? c_acc : acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pix_valid_q <= emit;
			pix_x_q     <= !emit ? '0 : (c_major_is_x ? c_major : c_minor);
			pix_y_q     <= !emit ? '0 : (c_major_is_x ? c_minor : c_major);
			pix_color_q <= emit ? c_color : '0;
			pix_last_q  <= emit && last;
		end
	end

	assign pixel_out.valid       = out_valid_q;
	assign pixel_out.pixel_valid = pix_valid_q;
	assign pixel_out.pixel_x     = pix_x_q;
	assign pixel_out.pixel_y     = pix_y_q;
	assign pixel_out.color_out   = pix_color_q;
	assign pixel_out.last_pixel  = pix_last_q;
endmodule

// ----- hdl/line_pixel_rasterizer_top.sv -----
// Line pixel rasterizer: front classifier, entry queue and pixel stepping back end.
// A command passes through the front stage register, the entry queue and the output register to the pixel output.
// Throughput: one command and one pixel per cycle while the pixel output is not stalled;
// the back end's remainder add, compare and subtract are combinational.
// Reset: arst_n clears the active line, the queue and the output register.
module line_pixel_rasterizer_top import lpr_pkg::*; #(
	parameter int COORD_BITS = 13
) (
	input  logic         clk,
	input  logic         arst_n,
	lpr_line_if.sink     line_in,
	lpr_pixel_if.source  pixel_out
);
	localparam int EB = entry_bits(COORD_BITS);

	logic          push, full, pop, not_empty;
	logic [EB-1:0] push_entry, head;

	lpr_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_in    (line_in),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	lpr_fifo #(.WIDTH(EB), .DEPTH(4)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	lpr_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (not_empty),
		.entry_in    (head),
		.pop         (pop),
		.pixel_out   (pixel_out)
	);
endmodule

// ----- test/line_pixel_rasterizer_top_tb.sv -----
// Self-checking testbench for the line pixel rasterizer, with its own line stepping predictor.
module line_pixel_rasterizer_top_tb;
	import lpr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS = 13;
	localparam int SETTLE_CYCLES = 10;
	localparam int REPORT_LINES = 100;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic                   pixel_valid;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [COLOR_BITS-1:0]  color;
		logic                   last;
	} pixel_t;

	logic clk;
	logic arst_n;

	lpr_line_if  #(.COORD_BITS(COORD_BITS)) line_bus ();
	lpr_pixel_if #(.COORD_BITS(COORD_BITS)) pixel_bus ();

	line_pixel_rasterizer_top #(.COORD_BITS(COORD_BITS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_in   (line_bus),
		.pixel_out (pixel_bus)
	);

	// predictor state
	bit                    line_active;
	bit                    major_is_x;
	coord_t                major_current;
	coord_t                major_end;
	coord_t                minor_current;
	bit                    minor_falls;
	bit [COORD_BITS:0]     major_span;
	bit [COORD_BITS:0]     minor_span;
	bit [COORD_BITS:0]     remainder_acc;
	bit [COLOR_BITS-1:0]   line_color;

	pixel_t pending_pixels[$];
	int     mismatch_count;
	int     sent_items;
	bit     send_steady;
	bit     recv_steady;

	always #5 clk = ~clk;

	task automatic report_error(input string msg);
		if (mismatch_count < REPORT_LINES)
			$display("ERROR %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic clear_line_state();
		line_active = 0;
		major_is_x = 0;
		major_current = '0;
		major_end = '0;
		minor_current = '0;
		minor_falls = 0;
		major_span = '0;
		minor_span = '0;
		remainder_acc = '0;
		line_color = '0;
	endtask

	// emit the current pixel, then advance along the major axis unless it was the last
	function automatic pixel_t step_pixel();
		pixel_t p;
		p.pixel_valid = 1'b1;
		p.x = major_is_x ? major_current : minor_current;
		p.y = major_is_x ? minor_current : major_current;
		p.color = line_color;
		p.last = (major_current == major_end);
		if (p.last) begin
			line_active = 0;
		end else begin
			major_current = major_current + 1'b1;
			remainder_acc = remainder_acc + minor_span;
			if (remainder_acc >= major_span) begin
				remainder_acc = remainder_acc - major_span;
				minor_current = minor_falls ? minor_current - 1'b1 : minor_current + 1'b1;
			end
		end
		return p;
	endfunction

	function automatic pixel_t rasterize(input logic cmd, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey, input logic [COLOR_BITS-1:0] color);
		int x0, y0, x1, y1, adx, ady, amn, mj0, mj1, mn0, mn1, t;
		if (cmd == CMD_LOAD) begin
			x0 = sx;
			y0 = sy;
			x1 = ex;
			y1 = ey;
			adx = (x0 >= x1) ? x0 - x1 : x1 - x0;
			ady = (y0 >= y1) ? y0 - y1 : y1 - y0;
			major_is_x = (adx >= ady);
			if (major_is_x) begin
				mj0 = x0; mj1 = x1; mn0 = y0; mn1 = y1; amn = ady;
			end else begin
				mj0 = y0; mj1 = y1; mn0 = x0; mn1 = x1; amn = adx;
			end
			if (mj1 < mj0) begin
				t = mj0; mj0 = mj1; mj1 = t;
				t = mn0; mn0 = mn1; mn1 = t;
			end
			major_current = coord_t'(mj0);
			major_end = coord_t'(mj1);
			minor_current = coord_t'(mn0);
			minor_falls = (mn1 < mn0);
			major_span = (COORD_BITS+1)'(mj1 - mj0 + 1);
			minor_span = (amn == 0) ? '0 : (COORD_BITS+1)'(amn + 1);
			remainder_acc = '0;
			line_color = color;
			line_active = 1;
			return step_pixel();
		end
		if (!line_active)
			return '0;
		return step_pixel();
	endfunction

	task automatic send_command(input logic cmd, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey, input logic [COLOR_BITS-1:0] color);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			line_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		line_bus.valid <= 1'b1;
		line_bus.command <= cmd;
		line_bus.start_x <= sx;
		line_bus.start_y <= sy;
		line_bus.end_x <= ex;
		line_bus.end_y <= ey;
		line_bus.pixel_color <= color;
		do @(posedge clk); while (!line_bus.ready);
		pending_pixels.insert(pending_pixels.size(), rasterize(cmd, sx, sy, ex, ey, color));
		sent_items++;
	endtask

	task automatic run_line(input coord_t sx, input coord_t sy, input coord_t ex,
			input coord_t ey, input logic [COLOR_BITS-1:0] color, input int nexts);
		send_command(CMD_LOAD, sx, sy, ex, ey, color);
		repeat (nexts)
			send_command(CMD_NEXT, coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), coord_t'($urandom), COLOR_BITS'($urandom));
	endtask

	task automatic wait_pixels_drained();
		line_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_next_without_line();
		send_command(CMD_NEXT, coord_t'(-4096), coord_t'(4095), coord_t'(-4096),
			coord_t'(4095), 24'hFFFFFF);
		send_command(CMD_NEXT, coord_t'(4095), coord_t'(-4096), coord_t'(4095),
			coord_t'(-4096), 24'h000000);
	endtask

	task automatic test_single_point();
		run_line(coord_t'(4095), coord_t'(-4096), coord_t'(4095), coord_t'(-4096),
			24'h000000, 1);
	endtask

	task automatic test_extreme_lines();
		run_line(coord_t'(-4096), coord_t'(-4096), coord_t'(4095), coord_t'(4095),
			24'hFFFFFF, 2);
		run_line(coord_t'(4095), coord_t'(4095), coord_t'(-4096), coord_t'(-4096),
			24'hA5A5A5, 2);
	endtask

	task automatic test_orientations();
		run_line(coord_t'(3), coord_t'(3), coord_t'(0), coord_t'(0), 24'h123456, 3);
		run_line(coord_t'(0), coord_t'(5), coord_t'(2), coord_t'(0), 24'h00FF00, 6);
		run_line(coord_t'(-1), coord_t'(7), coord_t'(1), coord_t'(7), 24'hFF0000, 2);
	endtask

	task automatic test_random_lines(input int item_budget);
		int target, dx, dy, pixels, nexts, shape, pick;
		coord_t sx, sy, ex, ey;
		target = sent_items + item_budget;
		while (sent_items < target) begin
			send_steady = ($urandom_range(0, 7) == 0);
			recv_steady = ($urandom_range(0, 7) == 0);
			shape = $urandom_range(0, 9);
			sx = coord_t'($urandom);
			sy = coord_t'($urandom);
			if (shape < 7) begin
				dx = $urandom_range(0, 24);
				dy = $urandom_range(0, 24);
				if ($urandom_range(0, 1)) dx = -dx;
				if ($urandom_range(0, 1)) dy = -dy;
				ex = coord_t'(sx + dx);
				ey = coord_t'(sy + dy);
				dx = ex - sx;
				dy = ey - sy;
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				pixels = ((dx > dy) ? dx : dy) + 1;
				pick = $urandom_range(0, 9);
				if (pixels > 64)
					nexts = $urandom_range(0, 20);
				else if (pick < 6)
					nexts = pixels - 1;
				else if (pick < 8)
					nexts = pixels - 1 + $urandom_range(1, 3);
				else
					nexts = $urandom_range(0, pixels - 1);
				run_line(sx, sy, ex, ey, COLOR_BITS'($urandom), nexts);
			end else if (shape < 8) begin
				run_line(sx, sy, coord_t'($urandom), coord_t'($urandom),
					COLOR_BITS'($urandom), $urandom_range(0, 20));
			end else begin
				send_command(1'($urandom_range(0, 1)), sx, sy, coord_t'($urandom),
					coord_t'($urandom), COLOR_BITS'($urandom));
			end
		end
		send_steady = 0;
		recv_steady = 0;
	endtask

	initial begin
		pixel_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int stall;
			stall = recv_steady ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				pixel_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pixel_bus.ready <= 1'b1;
			do @(posedge clk); while (!(pixel_bus.valid && pixel_bus.ready));
		end
	end

	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (arst_n && pixel_bus.valid && pixel_bus.ready) begin
			if (pending_pixels.size() == 0) begin
				report_error("pixel transfer with nothing expected");
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_bus.pixel_valid !== want.pixel_valid)
					report_error($sformatf("pixel_valid %b, want %b",
						pixel_bus.pixel_valid, want.pixel_valid));
				if (pixel_bus.pixel_x !== want.x)
					report_error($sformatf("pixel_x %0d, want %0d", pixel_bus.pixel_x, want.x));
				if (pixel_bus.pixel_y !== want.y)
					report_error($sformatf("pixel_y %0d, want %0d", pixel_bus.pixel_y, want.y));
				if (pixel_bus.color_out !== want.color)
					report_error($sformatf("color_out %h, want %h",
						pixel_bus.color_out, want.color));
				if (pixel_bus.last_pixel !== want.last)
					report_error($sformatf("last_pixel %b, want %b",
						pixel_bus.last_pixel, want.last));
			end
		end
	end

	initial begin
		#4_000_000;
		$display("line_pixel_rasterizer_top_tb: done, errors");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		line_bus.valid = 1'b0;
		line_bus.command = CMD_NEXT;
		line_bus.start_x = '0;
		line_bus.start_y = '0;
		line_bus.end_x = '0;
		line_bus.end_y = '0;
		line_bus.pixel_color = '0;
		mismatch_count = 0;
		sent_items = 0;
		send_steady = 0;
		recv_steady = 0;
		clear_line_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_next_without_line();
		test_single_point();
		test_extreme_lines();
		test_orientations();
		wait_pixels_drained();
		test_random_lines(600);
		wait_pixels_drained();
		test_random_lines(650);
		wait_pixels_drained();

		if (mismatch_count == 0)
			$display("line_pixel_rasterizer_top_tb: done, clean");
		else
			$display("line_pixel_rasterizer_top_tb: done, errors");
		$finish;
	end

endmodule
